>>> rtl/mpct_pkg.sv
// ----------------------------------------------------------------------------
// mpct_pkg
// Shared types and constants for the mouse packet cursor tracker.
// ----------------------------------------------------------------------------
package mpct_pkg;

   localparam int DEFAULT_POSITION_BITS = 12;
   localparam int RES_BITS              = 12;
   localparam int DATA_BITS             = 8;
   localparam int DELTA_BITS            = DATA_BITS + 1;
   localparam int CSR_INDEX_BITS        = 1;

   localparam logic [RES_BITS-1:0] HRES_RESET = 12'd1280;
   localparam logic [RES_BITS-1:0] VRES_RESET = 12'd1024;

   localparam int CURSOR_COL_RESET = 640;
   localparam int CURSOR_ROW_RESET = 512;

   // Bit positions inside the first byte of a packet.
   localparam int LEFT_POS   = 0;
   localparam int RIGHT_POS  = 1;
   localparam int MIDDLE_POS = 2;
   localparam int SYNC_POS   = 3;
   localparam int XSIGN_POS  = 4;
   localparam int YSIGN_POS  = 5;
   localparam int XOVF_POS   = 6;
   localparam int YOVF_POS   = 7;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_HRES = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VRES = 1'b1;

   typedef enum logic [1:0] {
      SLOT_HEADER,
      SLOT_DX,
      SLOT_DY
   } slot_type;

   typedef struct packed {
      logic last_slot;    // the next byte completes a packet
      logic packet_done;  // a packet completes on this transaction
   } asm_status_type;

endpackage

>>> rtl/mpct_assembler.sv
// ----------------------------------------------------------------------------
// mpct_assembler
// Byte slot tracker that gathers three-byte packets and regains sync.
// ----------------------------------------------------------------------------
module mpct_assembler (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          byte_accept,
   input  logic [mpct_pkg::DATA_BITS-1:0] data_byte,
   output mpct_pkg::asm_status_type      status,
   output logic [mpct_pkg::DATA_BITS-1:0] first_byte,
   output logic [mpct_pkg::DATA_BITS-1:0] second_byte
);
   import mpct_pkg::*;

   slot_type                slot_ff, slot_in;
   logic [DATA_BITS-1:0]    first_byte_ff, first_byte_in;
   logic [DATA_BITS-1:0]    second_byte_ff, second_byte_in;

   always_comb begin
      slot_in = slot_ff;
      if (byte_accept) begin
         case (slot_ff)
            SLOT_HEADER: begin
               // A header without the always-one bit is dropped to resync.
               if (data_byte[SYNC_POS]) slot_in = SLOT_DX;
            end
            SLOT_DX: slot_in = SLOT_DY;
            SLOT_DY: slot_in = SLOT_HEADER;
            default: slot_in = SLOT_HEADER;
         endcase
      end
   end

   always_comb begin
      first_byte_in  = first_byte_ff;
      second_byte_in = second_byte_ff;
      status         = '0;
      case (slot_ff)
         SLOT_HEADER: begin
            if (byte_accept && data_byte[SYNC_POS]) first_byte_in = data_byte;
         end
         SLOT_DX: begin
            if (byte_accept) second_byte_in = data_byte;
         end
         default: begin
            status.last_slot   = 1'b1;
            status.packet_done = byte_accept;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= SLOT_HEADER;
      end else begin
         slot_ff <= slot_in;
      end
      first_byte_ff  <= first_byte_in;
      second_byte_ff <= second_byte_in;
   end

   assign first_byte  = first_byte_ff;
   assign second_byte = second_byte_ff;

   a_done_returns_to_header: assert property (@(posedge clock) disable iff (reset)
      status.packet_done |=> slot_ff == SLOT_HEADER)
      else $error("slot did not return to header after a packet");

   a_bad_header_dropped: assert property (@(posedge clock) disable iff (reset)
      (slot_ff == SLOT_HEADER) && byte_accept && !data_byte[SYNC_POS]
      |=> slot_ff == SLOT_HEADER)
      else $error("unsynchronized header byte was not dropped");

   a_reset_to_header: assert property (@(posedge clock)
      reset |=> slot_ff == SLOT_HEADER)
      else $error("slot not at header after reset");

endmodule

>>> rtl/mpct_cursor.sv
// ----------------------------------------------------------------------------
// mpct_cursor
// Cursor position registers with the clamped move applied per packet.
// ----------------------------------------------------------------------------
module mpct_cursor #(
   parameter int POSITION_BITS = mpct_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                update,
   input  logic signed [mpct_pkg::DELTA_BITS-1:0] delta_x,
   input  logic signed [mpct_pkg::DELTA_BITS-1:0] delta_y,
   input  logic [mpct_pkg::RES_BITS-1:0]       horiz_res,
   input  logic [mpct_pkg::RES_BITS-1:0]       vert_res,
   output logic [POSITION_BITS-1:0]            cursor_x_next,
   output logic [POSITION_BITS-1:0]            cursor_y_next
);
   import mpct_pkg::*;

   // Wide enough for position plus or minus a delta, and for any resolution.
   localparam int SUM_BITS = POSITION_BITS + 2;
   localparam logic signed [SUM_BITS-1:0] POS_LIMIT =
      SUM_BITS'((1 << POSITION_BITS) - 1);

   logic [POSITION_BITS-1:0]  cursor_col_ff, cursor_col_in;
   logic [POSITION_BITS-1:0]  cursor_row_ff, cursor_row_in;
   logic signed [SUM_BITS-1:0] col_sum;
   logic signed [SUM_BITS-1:0] row_sum;

   function automatic logic [POSITION_BITS-1:0] clamp_axis(
      input logic signed [SUM_BITS-1:0] pos,
      input logic [RES_BITS-1:0]        res
   );
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] result;
      // A zero resolution pins the axis at zero.
      if (res == '0) hi = '0;
      else           hi = $signed(SUM_BITS'(res) - SUM_BITS'(1));
      if (hi > POS_LIMIT) hi = POS_LIMIT;
      if (pos < 0)       result = '0;
      else if (pos > hi) result = hi;
      else               result = pos;
      return result[POSITION_BITS-1:0];
   endfunction

   always_comb begin
      col_sum       = $signed(SUM_BITS'(cursor_col_ff)) + SUM_BITS'(delta_x);
      // Upward movement is positive, while rows grow downward.
      row_sum       = $signed(SUM_BITS'(cursor_row_ff)) - SUM_BITS'(delta_y);
      cursor_x_next = clamp_axis(col_sum, horiz_res);
      cursor_y_next = clamp_axis(row_sum, vert_res);
      cursor_col_in = update ? cursor_x_next : cursor_col_ff;
      cursor_row_in = update ? cursor_y_next : cursor_row_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_col_ff <= POSITION_BITS'(CURSOR_COL_RESET);
         cursor_row_ff <= POSITION_BITS'(CURSOR_ROW_RESET);
      end else begin
         cursor_col_ff <= cursor_col_in;
         cursor_row_ff <= cursor_row_in;
      end
   end

endmodule

>>> rtl/ps2_mouse_packet_cursor_tracker_core.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor_tracker_core
// Three-byte PS/2 mouse packet decoder that also tracks a clamped cursor.
// ----------------------------------------------------------------------------
// Raw mouse bytes arrive one per transaction on the req_ channel. A header
// byte whose bit 3 is clear is dropped so the decoder falls back into step.
// The third byte of a packet produces one transaction on the rsp_ channel
// with the buttons, overflow flags, sign-extended deltas and the new cursor.
// The first two bytes of a packet produce no response.
// Latency: the response is valid on the cycle after the third byte is taken.
// Throughput: one byte per cycle; the cursor add and clamp sit between the
// byte registers and the response register, so nothing iterates.
// When the receiver stalls, header and x bytes are still taken; the third
// byte waits only while the response register is full and not being drained.
// The csr_ port writes the horizontal and vertical resolutions at any time
// with no handshake. Reset empties the response register, returns the slot
// tracker to the header slot, sets the resolutions to 1280 by 1024 and puts
// the cursor at column 640, row 512.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_cursor_tracker_core #(
   parameter int POSITION_BITS = mpct_pkg::DEFAULT_POSITION_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [mpct_pkg::DATA_BITS-1:0]         req_mouse_data_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_left_button,
   output logic                                   rsp_right_button,
   output logic                                   rsp_middle_button,
   output logic                                   rsp_x_overflow,
   output logic                                   rsp_y_overflow,
   output logic signed [mpct_pkg::DELTA_BITS-1:0] rsp_delta_x,
   output logic signed [mpct_pkg::DELTA_BITS-1:0] rsp_delta_y,
   output logic [POSITION_BITS-1:0]               rsp_cursor_x,
   output logic [POSITION_BITS-1:0]               rsp_cursor_y,
   input  logic                                   csr_write_enable,
   input  logic [mpct_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mpct_pkg::RES_BITS-1:0]          csr_write_data
);
   import mpct_pkg::*;

   asm_status_type             asm_status;
   logic                       byte_accept;
   logic [DATA_BITS-1:0]       first_byte;
   logic [DATA_BITS-1:0]       second_byte;
   logic signed [DELTA_BITS-1:0] delta_x;
   logic signed [DELTA_BITS-1:0] delta_y;
   logic [POSITION_BITS-1:0]   cursor_x_next;
   logic [POSITION_BITS-1:0]   cursor_y_next;

   logic [RES_BITS-1:0]        horiz_res_ff, horiz_res_in;
   logic [RES_BITS-1:0]        vert_res_ff, vert_res_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0]       rsp_header_ff, rsp_header_in;
   logic signed [DELTA_BITS-1:0] rsp_delta_x_ff, rsp_delta_x_in;
   logic signed [DELTA_BITS-1:0] rsp_delta_y_ff, rsp_delta_y_in;
   logic [POSITION_BITS-1:0]   rsp_cursor_x_ff, rsp_cursor_x_in;
   logic [POSITION_BITS-1:0]   rsp_cursor_y_ff, rsp_cursor_y_in;

   // Only a packet-completing byte needs room in the response register.
   assign req_ready   = !asm_status.last_slot || !rsp_valid_ff || rsp_ready;
   assign byte_accept = req_valid && req_ready;

   mpct_assembler u_assembler (
      .clock       (clock),
      .reset       (reset),
      .byte_accept (byte_accept),
      .data_byte   (req_mouse_data_byte),
      .status      (asm_status),
      .first_byte  (first_byte),
      .second_byte (second_byte)
   );

   assign delta_x = $signed({first_byte[XSIGN_POS], second_byte});
   assign delta_y = $signed({first_byte[YSIGN_POS], req_mouse_data_byte});

   mpct_cursor #(
      .POSITION_BITS (POSITION_BITS)
   ) u_cursor (
      .clock         (clock),
      .reset         (reset),
      .update        (asm_status.packet_done),
      .delta_x       (delta_x),
      .delta_y       (delta_y),
      .horiz_res     (horiz_res_ff),
      .vert_res      (vert_res_ff),
      .cursor_x_next (cursor_x_next),
      .cursor_y_next (cursor_y_next)
   );

   always_comb begin
      horiz_res_in = horiz_res_ff;
      vert_res_in  = vert_res_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_HRES: horiz_res_in = csr_write_data;
            CSR_VRES: vert_res_in  = csr_write_data;
            default:  horiz_res_in = horiz_res_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in    = asm_status.packet_done || (rsp_valid_ff && !rsp_ready);
      rsp_header_in   = rsp_header_ff;
      rsp_delta_x_in  = rsp_delta_x_ff;
      rsp_delta_y_in  = rsp_delta_y_ff;
      rsp_cursor_x_in = rsp_cursor_x_ff;
      rsp_cursor_y_in = rsp_cursor_y_ff;
      if (asm_status.packet_done) begin
         rsp_header_in   = first_byte;
         rsp_delta_x_in  = delta_x;
         rsp_delta_y_in  = delta_y;
         rsp_cursor_x_in = cursor_x_next;
         rsp_cursor_y_in = cursor_y_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         horiz_res_ff <= HRES_RESET;
         vert_res_ff  <= VRES_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         horiz_res_ff <= horiz_res_in;
         vert_res_ff  <= vert_res_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_header_ff   <= rsp_header_in;
      rsp_delta_x_ff  <= rsp_delta_x_in;
      rsp_delta_y_ff  <= rsp_delta_y_in;
      rsp_cursor_x_ff <= rsp_cursor_x_in;
      rsp_cursor_y_ff <= rsp_cursor_y_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_button   = rsp_header_ff[LEFT_POS];
   assign rsp_right_button  = rsp_header_ff[RIGHT_POS];
   assign rsp_middle_button = rsp_header_ff[MIDDLE_POS];
   assign rsp_x_overflow    = rsp_header_ff[XOVF_POS];
   assign rsp_y_overflow    = rsp_header_ff[YOVF_POS];
   assign rsp_delta_x       = rsp_delta_x_ff;
   assign rsp_delta_y       = rsp_delta_y_ff;
   assign rsp_cursor_x      = rsp_cursor_x_ff;
   assign rsp_cursor_y      = rsp_cursor_y_ff;

   a_packet_gives_response: assert property (@(posedge clock) disable iff (reset)
      asm_status.packet_done |=> rsp_valid_ff)
      else $error("completed packet did not produce a response");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !asm_status.packet_done)
      else $error("pending response overwritten by a new packet");

   a_only_third_byte_stalls: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> asm_status.last_slot && rsp_valid_ff)
      else $error("input stalled outside the packet-completing slot");

   a_reset_empties_response: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("response register not empty after reset");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 mouse packet decoder and cursor tracker.
// ----------------------------------------------------------------------------
// Raw mouse bytes are driven on the req_ channel and the decoded reports are
// checked on the rsp_ channel. A behavioral tracker in the bench follows the
// packet framing, the sign extension and the clamped cursor, and queues one
// expected report per completed packet. The run starts with directed packets.
// It then moves through several screen sizes, the extremes among them, with
// random packets and stray bytes, random idling on both sides, and one long
// receiver stall.
// ----------------------------------------------------------------------------
module tb;
   import mpct_pkg::*;

   localparam int POSITION_BITS = DEFAULT_POSITION_BITS;
   localparam int POSITION_MAX  = (1 << POSITION_BITS) - 1;
   localparam int PHASE_COUNT   = 6;
   localparam int PHASE_BYTES   = 110;
   localparam int SETTLE_CYCLES = 4;

   typedef struct {
      logic                      left;
      logic                      right;
      logic                      middle;
      logic                      x_ovf;
      logic                      y_ovf;
      logic signed [DELTA_BITS-1:0] dx;
      logic signed [DELTA_BITS-1:0] dy;
      logic [POSITION_BITS-1:0]  col;
      logic [POSITION_BITS-1:0]  row;
   } mouse_report_type;

   class cursor_report_checker;
      logic [RES_BITS-1:0] hres;
      logic [RES_BITS-1:0] vres;
      slot_type            slot;
      logic [DATA_BITS-1:0] header;
      logic [DATA_BITS-1:0] x_byte;
      int                  col;
      int                  row;
      int                  bytes_used;
      int                  errors;
      mouse_report_type    pending[$];

      function new();
         hres       = HRES_RESET;
         vres       = VRES_RESET;
         slot       = SLOT_HEADER;
         header     = '0;
         x_byte     = '0;
         col        = CURSOR_COL_RESET;
         row        = CURSOR_ROW_RESET;
         bytes_used = 0;
         errors     = 0;
      endfunction

      function void set_resolution(logic [CSR_INDEX_BITS-1:0] idx,
                                   logic [RES_BITS-1:0] value);
         if (idx == CSR_HRES) hres = value;
         else if (idx == CSR_VRES) vres = value;
      endfunction

      function int clamp_axis(int pos, logic [RES_BITS-1:0] res);
         int hi;
         hi = (res == 0) ? 0 : int'(res) - 1;
         if (hi > POSITION_MAX) hi = POSITION_MAX;
         if (pos < 0) pos = 0;
         if (pos > hi) pos = hi;
         return pos;
      endfunction

      // Follows the framing of one accepted byte; the third byte of a packet
      // moves the cursor and queues the report it should produce.
      function void note_byte(logic [DATA_BITS-1:0] b);
         mouse_report_type rpt;
         case (slot)
            SLOT_HEADER: begin
               if (b[SYNC_POS]) begin
                  header = b;
                  slot   = SLOT_DX;
                  bytes_used++;
               end
            end
            SLOT_DX: begin
               x_byte = b;
               slot   = SLOT_DY;
               bytes_used++;
            end
            default: begin
               rpt.dx     = {header[XSIGN_POS], x_byte};
               rpt.dy     = {header[YSIGN_POS], b};
               col        = clamp_axis(col + rpt.dx, hres);
               row        = clamp_axis(row - rpt.dy, vres);
               rpt.left   = header[LEFT_POS];
               rpt.right  = header[RIGHT_POS];
               rpt.middle = header[MIDDLE_POS];
               rpt.x_ovf  = header[XOVF_POS];
               rpt.y_ovf  = header[YOVF_POS];
               rpt.col    = col[POSITION_BITS-1:0];
               rpt.row    = row[POSITION_BITS-1:0];
               pending.push_back(rpt);
               header = '0;
               x_byte = '0;
               slot   = SLOT_HEADER;
               bytes_used++;
            end
         endcase
      endfunction

      function void check_report(mouse_report_type got);
         mouse_report_type exp;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: report with no packet outstanding: x=%0d y=%0d",
                        $realtime, got.col, got.row);
            return;
         end
         exp = pending.pop_front();
         if (got.left !== exp.left || got.right !== exp.right ||
             got.middle !== exp.middle || got.x_ovf !== exp.x_ovf ||
             got.y_ovf !== exp.y_ovf || got.dx !== exp.dx || got.dy !== exp.dy ||
             got.col !== exp.col || got.row !== exp.row) begin
            errors++;
            if (errors <= 10) begin
               $display("%0t: report mismatch", $realtime);
               $display("   expected lrm=%b%b%b ovf=%b%b dx=%0d dy=%0d x=%0d y=%0d",
                        exp.left, exp.right, exp.middle, exp.x_ovf, exp.y_ovf,
                        exp.dx, exp.dy, exp.col, exp.row);
               $display("   actual   lrm=%b%b%b ovf=%b%b dx=%0d dy=%0d x=%0d y=%0d",
                        got.left, got.right, got.middle, got.x_ovf, got.y_ovf,
                        got.dx, got.dy, got.col, got.row);
            end
         end
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic [DATA_BITS-1:0]          req_mouse_data_byte;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_left_button;
   logic                          rsp_right_button;
   logic                          rsp_middle_button;
   logic                          rsp_x_overflow;
   logic                          rsp_y_overflow;
   logic signed [DELTA_BITS-1:0]  rsp_delta_x;
   logic signed [DELTA_BITS-1:0]  rsp_delta_y;
   logic [POSITION_BITS-1:0]      rsp_cursor_x;
   logic [POSITION_BITS-1:0]      rsp_cursor_y;
   logic                          csr_write_enable;
   logic [CSR_INDEX_BITS-1:0]     csr_index;
   logic [RES_BITS-1:0]           csr_write_data;

   cursor_report_checker tracker;
   bit                   no_idle;
   bit                   hold_rsp_request;

   ps2_mouse_packet_cursor_tracker_core #(
      .POSITION_BITS(POSITION_BITS)
   ) i_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mouse_data_byte (req_mouse_data_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_left_button     (rsp_left_button),
      .rsp_right_button    (rsp_right_button),
      .rsp_middle_button   (rsp_middle_button),
      .rsp_x_overflow      (rsp_x_overflow),
      .rsp_y_overflow      (rsp_y_overflow),
      .rsp_delta_x         (rsp_delta_x),
      .rsp_delta_y         (rsp_delta_y),
      .rsp_cursor_x        (rsp_cursor_x),
      .rsp_cursor_y        (rsp_cursor_y),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   // Offers one byte and returns at the edge where the transaction completes.
   task automatic send_byte(input logic [DATA_BITS-1:0] b);
      while (!no_idle && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_mouse_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_byte(b);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.pending.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_resolutions(input logic [RES_BITS-1:0] h,
                                    input logic [RES_BITS-1:0] v);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_HRES;
      csr_write_data   <= h;
      @(posedge clock);
      tracker.set_resolution(CSR_HRES, h);
      csr_index        <= CSR_VRES;
      csr_write_data   <= v;
      @(posedge clock);
      tracker.set_resolution(CSR_VRES, v);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly well-formed packets with random content, with stray bytes mixed
   // in so that the decoder has to drop headers and fall back into step.
   task automatic random_traffic(input int target, input bit with_pressure);
      int  start;
      bit  stalled;
      bit  paused;
      logic [DATA_BITS-1:0] hdr;
      start   = tracker.bytes_used;
      stalled = 1'b0;
      paused  = 1'b0;
      while (tracker.bytes_used - start < target) begin
         if (with_pressure && !stalled && tracker.bytes_used - start > 30) begin
            hold_rsp_request = 1'b1;
            stalled          = 1'b1;
         end
         if (with_pressure && !paused && tracker.bytes_used - start > 75) begin
            wait_drained();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 85) begin
            hdr           = DATA_BITS'($urandom);
            hdr[SYNC_POS] = 1'b1;
            send_byte(hdr);
            send_byte(DATA_BITS'($urandom));
            send_byte(DATA_BITS'($urandom));
         end else begin
            send_byte(DATA_BITS'($urandom));
         end
      end
   endtask

   initial begin : req_side
      logic [DATA_BITS-1:0] directed_bytes[$];
      logic [RES_BITS-1:0]  hres_plan[PHASE_COUNT];
      logic [RES_BITS-1:0]  vres_plan[PHASE_COUNT];
      int                   n;

      tracker             = new();
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_mouse_data_byte <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_HRES;
      csr_write_data      <= '0;
      no_idle             = 1'b0;
      hold_rsp_request    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset resolutions: two headers with bit 3 clear are dropped, then a
      // still packet reports the reset cursor.
      directed_bytes = '{8'h00, 8'hF7, 8'h08, 8'h00, 8'h00};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_drained();

      // Shrink the screen below the reset cursor; the next packet clamps it.
      // Then full negative and positive deltas, overflow flags and headers
      // used as delta bytes.
      write_resolutions(12'd300, 12'd200);
      directed_bytes = '{8'hFF, 8'h00, 8'h00,  8'h0F, 8'hFF, 8'hFF,
                         8'h38, 8'h01, 8'hFF,  8'hC8, 8'h80, 8'h7F,
                         8'h08, 8'h08, 8'h00,  8'h17, 8'h00, 8'h80};
      foreach (directed_bytes[i]) send_byte(directed_bytes[i]);
      wait_drained();

      hres_plan = '{HRES_RESET, 12'd4095, 12'd0, 12'd1,    12'd0, 12'd4095};
      vres_plan = '{VRES_RESET, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1};
      hres_plan[4] = RES_BITS'($urandom_range(1, 700));
      vres_plan[4] = RES_BITS'($urandom_range(1, 700));
      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_resolutions(hres_plan[p], vres_plan[p]);
         no_idle = (p == 1);
         random_traffic(PHASE_BYTES, p == 0);
         wait_drained();
      end

      req_valid <= 1'b0;
      n = 0;
      while (tracker.pending.size() != 0 && n < 5000) begin
         @(posedge clock);
         n++;
      end
      repeat (10) @(posedge clock);
      tracker.errors += tracker.pending.size();
      if (tracker.errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin : rsp_side
      int               hold_left;
      bit               hold_done;
      mouse_report_type got;
      hold_left = 0;
      hold_done = 1'b0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            got.left   = rsp_left_button;
            got.right  = rsp_right_button;
            got.middle = rsp_middle_button;
            got.x_ovf  = rsp_x_overflow;
            got.y_ovf  = rsp_y_overflow;
            got.dx     = rsp_delta_x;
            got.dy     = rsp_delta_y;
            got.col    = rsp_cursor_x;
            got.row    = rsp_cursor_y;
            tracker.check_report(got);
         end
         // A long hold-off lets the response register fill so that the
         // third byte of the next packet has to wait.
         if (hold_rsp_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 90;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 7);
         end
      end
   end

endmodule

>>> filelist.f
rtl/mpct_pkg.sv
rtl/mpct_assembler.sv
rtl/mpct_cursor.sv
rtl/ps2_mouse_packet_cursor_tracker_core.sv
tb/sv/tb.sv
